[sv/tte_pkg.sv]
// tte_pkg: shared types and codes for the transposition table engine.
// Used by the front, back and top level modules. No dependencies.
package tte_pkg;

  localparam logic [1:0] ACT_PROBE  = 2'd0;
  localparam logic [1:0] ACT_SAVE   = 2'd1;
  localparam logic [1:0] ACT_FILL   = 2'd2;
  localparam logic [1:0] ACT_UNUSED = 2'd3;

  localparam int TAG_W   = 32;
  localparam int DA_W    = 16;
  localparam int PL_W    = 48;
  localparam int ENTRY_W = TAG_W + DA_W + PL_W;

  typedef struct packed {
    logic [1:0]         action;
    logic [31:0]        position_key;
    logic [1:0]         target_way;
    logic signed [15:0] score_value;
    logic signed [15:0] static_eval;
    logic               is_pv;
    logic [1:0]         bound_kind;
    logic [7:0]         search_depth;
    logic [15:0]        best_move;
  } item_t;

  typedef struct packed {
    logic               hit;
    logic [1:0]         chosen_way;
    logic [7:0]         entry_depth;
    logic [1:0]         entry_bound;
    logic               entry_pv;
    logic signed [15:0] entry_value;
    logic signed [15:0] entry_eval;
    logic [15:0]        entry_move;
    logic [9:0]         fill_permille;
  } res_t;

  typedef struct packed {
    logic clearing;
  } status_t;

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_EXEC,
    ST_FILL,
    ST_FILL_DONE
  } back_state_t;

endpackage

[sv/tte_ram.sv]
// tte_ram: generic simple dual-port RAM, one write and one registered read port.
// No dependencies.
module tte_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);
  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end
endmodule

[sv/tte_front.sv]
// tte_front: accepts items, reduces the key to a cluster index and queues them.
// Depends on tte_pkg.
module tte_front #(
  parameter int NUM_CLUSTERS = 1024
) (
  input  logic                            clk,
  input  logic                            rst,
  input  tte_pkg::status_t                status,
  input  logic                            push,
  output logic                            full,
  input  tte_pkg::item_t                  in_item,
  output logic                            out_valid,
  input  logic                            out_ready,
  output tte_pkg::item_t                  out_item,
  output logic [$clog2(NUM_CLUSTERS)-1:0] out_cluster
);
  import tte_pkg::*;

  localparam int CW = $clog2(NUM_CLUSTERS);
  localparam bit IS_POW2 = (NUM_CLUSTERS & (NUM_CLUSTERS - 1)) == 0;
  // ceil(2^(32+CW) / NUM_CLUSTERS); exact quotient for every 32-bit key
  localparam logic [63:0] RECIP64 =
    ((64'd1 << (32 + CW)) + 64'(NUM_CLUSTERS) - 64'd1) / 64'(NUM_CLUSTERS);
  localparam logic [32:0] RECIP = RECIP64[32:0];
  localparam logic [31:0] NC32  = 32'(NUM_CLUSTERS);

  logic          hold_valid;
  logic          hold_done;
  item_t         hold_item;
  logic          step;
  logic [64:0]   prod;
  logic [31:0]   quot;
  logic [31:0]   rem_full;
  logic [CW-1:0] rem;
  logic [CW-1:0] cluster_val;
  logic          accept;
  logic          enq;
  logic          deq;

  item_t         q_item [2];
  logic [CW-1:0] q_clu [2];
  logic          qwp;
  logic          qrp;
  logic [1:0]    qcnt;

  // key mod NUM_CLUSTERS: reciprocal multiply, then multiply back and subtract
  always_comb begin
    quot     = 32'(prod >> (32 + CW));
    rem_full = hold_item.position_key - quot * NC32;
  end

  assign cluster_val = IS_POW2 ? hold_item.position_key[CW-1:0] : rem;
  assign full   = hold_valid || status.clearing;
  assign accept = push && !full;
  assign enq    = hold_valid && hold_done && (qcnt != 2'd2);
  assign out_valid = qcnt != 2'd0;
  assign deq    = out_valid && out_ready;
  assign out_item    = q_item[qrp];
  assign out_cluster = q_clu[qrp];

  always_ff @(posedge clk) begin
    if (rst) begin
      hold_valid <= 1'b0;
      hold_done  <= 1'b0;
      step       <= 1'b0;
      qwp        <= 1'b0;
      qrp        <= 1'b0;
      qcnt       <= '0;
    end else begin
      if (accept) begin
        hold_valid <= 1'b1;
        hold_done  <= IS_POW2;
        step       <= 1'b0;
      end else if (enq) begin
        hold_valid <= 1'b0;
      end else if (hold_valid && !hold_done) begin
        step <= 1'b1;
        if (step) begin
          hold_done <= 1'b1;
        end
      end
      if (enq) begin
        qwp <= ~qwp;
      end
      if (deq) begin
        qrp <= ~qrp;
      end
      qcnt <= qcnt + {1'b0, enq} - {1'b0, deq};
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      hold_item <= in_item;
    end else if (hold_valid && !hold_done) begin
      if (!step) begin
        prod <= 65'(hold_item.position_key) * 65'(RECIP);
      end else begin
        rem <= rem_full[CW-1:0];
      end
    end
    if (enq) begin
      q_item[qwp] <= hold_item;
      q_clu[qwp]  <= cluster_val;
    end
  end
endmodule

[sv/tte_back.sv]
// tte_back: table memories, clearing pass, probe/save execution, fill walk and
// the result queue. Depends on tte_pkg and tte_ram.
module tte_back #(
  parameter int NUM_CLUSTERS    = 1024,
  parameter int WAYS            = 3,
  parameter int SAMPLE_CLUSTERS = 1000
) (
  input  logic                            clk,
  input  logic                            rst,
  input  logic [4:0]                      gen,
  input  logic                            in_valid,
  output logic                            in_ready,
  input  tte_pkg::item_t                  in_item,
  input  logic [$clog2(NUM_CLUSTERS)-1:0] in_cluster,
  output tte_pkg::status_t                status,
  output logic                            empty,
  input  logic                            pop,
  output tte_pkg::res_t                   res
);
  import tte_pkg::*;

  localparam int CW = $clog2(NUM_CLUSTERS);
  localparam int SAMPLE = (SAMPLE_CLUSTERS < NUM_CLUSTERS) ? SAMPLE_CLUSTERS : NUM_CLUSTERS;
  localparam logic [CW-1:0] LAST_CLU  = CW'(NUM_CLUSTERS - 1);
  localparam logic [CW-1:0] LAST_SAMP = CW'(SAMPLE - 1);

  back_state_t   state;
  back_state_t   state_next;
  item_t         cur_item;
  logic [CW-1:0] clr_cnt;
  logic [CW-1:0] fa;
  logic          fill_first;
  logic [9:0]    fq;
  logic [1:0]    fr;

  logic [CW-1:0]      raddr;
  logic [CW-1:0]      cur_cluster;
  logic [ENTRY_W-1:0] rd [WAYS];
  logic [WAYS-1:0]    we;
  logic [CW-1:0]      waddr;
  logic [ENTRY_W-1:0] wdata;

  logic       take;
  logic       push_res;
  res_t       new_res;
  logic [9:0] fq_next;
  logic [1:0] fr_next;
  logic       acc_en;

  res_t       ofifo [2];
  logic       owp;
  logic       orp;
  logic [1:0] ocnt;
  logic       opop;

  genvar g;
  generate
    for (g = 0; g < WAYS; g++) begin : g_way
      tte_ram #(.WIDTH(ENTRY_W), .DEPTH(NUM_CLUSTERS)) u_ram (
        .clk  (clk),
        .we   (we[g]),
        .waddr(waddr),
        .wdata(wdata),
        .raddr(raddr),
        .rdata(rd[g])
      );
    end
  endgenerate

  assign in_ready = (state == ST_IDLE) && (ocnt != 2'd2);
  assign take     = in_ready && in_valid;
  assign status.clearing = (state == ST_CLEAR);

  // next state
  always_comb begin
    state_next = state;
    case (state)
      ST_CLEAR: begin
        if (clr_cnt == LAST_CLU) state_next = ST_IDLE;
      end
      ST_IDLE: begin
        if (take) state_next = (in_item.action == ACT_FILL) ? ST_FILL : ST_EXEC;
      end
      ST_EXEC: state_next = ST_IDLE;
      ST_FILL: begin
        if (fa == LAST_SAMP) state_next = ST_FILL_DONE;
      end
      ST_FILL_DONE: state_next = ST_IDLE;
      default: state_next = ST_IDLE;
    endcase
  end

  // fill tally: quotient and remainder by WAYS kept as the walk goes
  always_comb begin
    logic [2:0] cnt;
    logic [2:0] sum;
    cnt = '0;
    for (int i = 0; i < WAYS; i++) begin
      if (rd[i][63:56] != 8'd0 && rd[i][55:51] == gen) cnt = cnt + 3'd1;
    end
    sum = {1'b0, fr} + cnt;
    if (sum >= 3'(WAYS)) begin
      fr_next = 2'(sum - 3'(WAYS));
      fq_next = fq + 10'd1;
    end else begin
      fr_next = sum[1:0];
      fq_next = fq;
    end
  end

  // outputs: memory ports, execution and result
  always_comb begin
    logic [31:0]       key;
    logic              hit_any;
    logic [1:0]        sel;
    logic signed [9:0] best;
    logic signed [9:0] score;
    logic [7:0]        age;
    logic [ENTRY_W-1:0] ent;
    logic [15:0]       da;
    logic [47:0]       pl;
    logic              way_ok;
    logic              differs;
    logic              write_rest;
    logic [15:0]       mv;

    key = cur_item.position_key;
    hit_any = 1'b0;
    sel = '0;
    best = '0;
    score = '0;
    age = '0;
    ent = '0;
    da = '0;
    pl = '0;
    way_ok = 1'b0;
    differs = 1'b0;
    write_rest = 1'b0;
    mv = '0;
    we = '0;
    waddr = cur_cluster;
    wdata = '0;
    push_res = 1'b0;
    new_res = '0;
    acc_en = 1'b0;
    raddr = cur_cluster;

    case (state)
      ST_CLEAR: begin
        we = '1;
        waddr = clr_cnt;
      end
      ST_IDLE: raddr = in_cluster;
      ST_EXEC: begin
        push_res = 1'b1;
        if (cur_item.action == ACT_PROBE) begin
          for (int i = 0; i < WAYS; i++) begin
            if (!hit_any && rd[i][95:64] == key) begin
              hit_any = 1'b1;
              sel = 2'(i);
            end
          end
          if (!hit_any) begin
            for (int i = 0; i < WAYS; i++) begin
              age = (8'd7 + {gen, 3'b000} - rd[i][55:48]) & 8'hF8;
              score = $signed({2'b00, rd[i][63:56]}) - $signed({2'b00, age});
              if (i == 0 || score < best) begin
                best = score;
                sel = 2'(i);
              end
            end
          end
          for (int i = 0; i < WAYS; i++) begin
            if (2'(i) == sel) ent = rd[i];
          end
          da = ent[63:48];
          pl = ent[47:0];
          if (hit_any) begin
            da = {da[15:8], gen, da[2:0]};
            wdata = {ent[95:64], da, pl};
            for (int i = 0; i < WAYS; i++) we[i] = (2'(i) == sel);
          end
          new_res.hit = hit_any;
          new_res.chosen_way = sel;
          new_res.entry_depth = da[15:8];
          new_res.entry_bound = da[1:0];
          new_res.entry_pv = da[2];
          new_res.entry_value = pl[15:0];
          new_res.entry_eval = pl[31:16];
          new_res.entry_move = pl[47:32];
        end else if (cur_item.action == ACT_SAVE) begin
          for (int i = 0; i < WAYS; i++) begin
            if (2'(i) == cur_item.target_way) begin
              ent = rd[i];
              way_ok = 1'b1;
            end
          end
          if (way_ok) begin
            differs = ent[95:64] != key;
            write_rest = differs || (ent[63:56] < cur_item.search_depth);
            mv = (cur_item.best_move != 16'd0 || differs) ? cur_item.best_move : ent[47:32];
            if (write_rest) begin
              da = {cur_item.search_depth, gen, cur_item.is_pv, cur_item.bound_kind};
              pl = {mv, cur_item.static_eval, cur_item.score_value};
              wdata = {key, da, pl};
            end else begin
              da = ent[63:48];
              pl = {mv, ent[31:0]};
              wdata = {ent[95:64], da, pl};
            end
            for (int i = 0; i < WAYS; i++) we[i] = (2'(i) == cur_item.target_way);
            new_res.chosen_way = cur_item.target_way;
            new_res.entry_depth = da[15:8];
            new_res.entry_bound = da[1:0];
            new_res.entry_pv = da[2];
            new_res.entry_value = pl[15:0];
            new_res.entry_eval = pl[31:16];
            new_res.entry_move = pl[47:32];
          end
        end
      end
      ST_FILL: begin
        raddr = fa;
        acc_en = !fill_first;
      end
      ST_FILL_DONE: begin
        acc_en = 1'b1;
        push_res = 1'b1;
        new_res.fill_permille = fq_next;
      end
      default: ;
    endcase
  end

  assign empty = (ocnt == 2'd0);
  assign opop  = pop && !empty;
  assign res   = ofifo[orp];

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= ST_CLEAR;
      clr_cnt    <= '0;
      fa         <= '0;
      fill_first <= 1'b1;
      fq         <= '0;
      fr         <= '0;
      owp        <= 1'b0;
      orp        <= 1'b0;
      ocnt       <= '0;
    end else begin
      state <= state_next;
      if (state == ST_CLEAR) clr_cnt <= clr_cnt + CW'(1);
      if (take) begin
        fa         <= '0;
        fill_first <= 1'b1;
        fq         <= '0;
        fr         <= '0;
      end else begin
        if (state == ST_FILL) begin
          fa         <= fa + CW'(1);
          fill_first <= 1'b0;
        end
        if (acc_en) begin
          fq <= fq_next;
          fr <= fr_next;
        end
      end
      if (push_res) owp <= ~owp;
      if (opop) orp <= ~orp;
      ocnt <= ocnt + {1'b0, push_res} - {1'b0, opop};
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      cur_item    <= in_item;
      cur_cluster <= in_cluster;
    end
    if (push_res) ofifo[owp] <= new_res;
  end
endmodule

[sv/transposition_table_engine.sv]
// Transposition table engine: 3-way clusters, probe / save / fill query.
// Probe and save: front hold (key reduction by reciprocal multiply when
// NUM_CLUSTERS is not a power of two), front queue, registered cluster read,
// execute and write back, result queue. The front takes a new item only once
// the held one is queued. Fill query: walks the first SAMPLE_CLUSTERS clusters.
// Reset (synchronous) clears control, then a clearing pass over every cluster with full held high.
module transposition_table_engine #(
  parameter int NUM_CLUSTERS    = 1024,
  parameter int WAYS            = 3,
  parameter int SAMPLE_CLUSTERS = 1000
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               cfg_write,
  input  logic [4:0]         cfg_data,
  input  logic               push,
  output logic               full,
  input  logic [1:0]         action,
  input  logic [31:0]        position_key,
  input  logic [1:0]         target_way,
  input  logic signed [15:0] score_value,
  input  logic signed [15:0] static_eval,
  input  logic               is_pv,
  input  logic [1:0]         bound_kind,
  input  logic [7:0]         search_depth,
  input  logic [15:0]        best_move,
  output logic               empty,
  input  logic               pop,
  output logic               hit,
  output logic [1:0]         chosen_way,
  output logic [7:0]         entry_depth,
  output logic [1:0]         entry_bound,
  output logic               entry_pv,
  output logic signed [15:0] entry_value,
  output logic signed [15:0] entry_eval,
  output logic [15:0]        entry_move,
  output logic [9:0]         fill_permille
);
  import tte_pkg::*;

  localparam int CW = $clog2(NUM_CLUSTERS);

  logic [4:0]    search_generation;
  item_t         in_item;
  item_t         q_item;
  logic [CW-1:0] q_cluster;
  logic          q_valid;
  logic          q_ready;
  status_t       status;
  res_t          res;

  always_ff @(posedge clk) begin
    if (rst) begin
      search_generation <= '0;
    end else if (cfg_write) begin
      search_generation <= cfg_data;
    end
  end

  always_comb begin
    in_item.action       = action;
    in_item.position_key = position_key;
    in_item.target_way   = target_way;
    in_item.score_value  = score_value;
    in_item.static_eval  = static_eval;
    in_item.is_pv        = is_pv;
    in_item.bound_kind   = bound_kind;
    in_item.search_depth = search_depth;
    in_item.best_move    = best_move;
  end

  tte_front #(.NUM_CLUSTERS(NUM_CLUSTERS)) u_front (
    .clk        (clk),
    .rst        (rst),
    .status     (status),
    .push       (push),
    .full       (full),
    .in_item    (in_item),
    .out_valid  (q_valid),
    .out_ready  (q_ready),
    .out_item   (q_item),
    .out_cluster(q_cluster)
  );

  tte_back #(
    .NUM_CLUSTERS   (NUM_CLUSTERS),
    .WAYS           (WAYS),
    .SAMPLE_CLUSTERS(SAMPLE_CLUSTERS)
  ) u_back (
    .clk       (clk),
    .rst       (rst),
    .gen       (search_generation),
    .in_valid  (q_valid),
    .in_ready  (q_ready),
    .in_item   (q_item),
    .in_cluster(q_cluster),
    .status    (status),
    .empty     (empty),
    .pop       (pop),
    .res       (res)
  );

  assign hit           = res.hit;
  assign chosen_way    = res.chosen_way;
  assign entry_depth   = res.entry_depth;
  assign entry_bound   = res.entry_bound;
  assign entry_pv      = res.entry_pv;
  assign entry_value   = res.entry_value;
  assign entry_eval    = res.entry_eval;
  assign entry_move    = res.entry_move;
  assign fill_permille = res.fill_permille;
endmodule

[sv/tte_checker.sv]
// tte_checker: port-level assertions for transposition_table_engine, and its bind.
// No dependencies.
module tte_checker (
  input logic       clk,
  input logic       rst,
  input logic       full,
  input logic       empty,
  input logic       pop,
  input logic       hit,
  input logic [1:0] chosen_way,
  input logic [7:0] entry_depth,
  input logic [9:0] fill_permille
);
  // clearing pass holds off input right after reset
  a_full_after_rst: assert property (@(posedge clk) rst |=> full)
    else $error("full low right after reset");

  a_empty_after_rst: assert property (@(posedge clk) rst |=> empty)
    else $error("result shown right after reset");

  a_hit_no_fill: assert property (@(posedge clk) disable iff (rst)
    (!empty && hit) |-> (fill_permille == 10'd0))
    else $error("hit result carries a fill count");

  a_fill_clean: assert property (@(posedge clk) disable iff (rst)
    (!empty && fill_permille != 10'd0) |->
      (!hit && chosen_way == 2'd0 && entry_depth == 8'd0))
    else $error("fill result carries entry fields");

  a_result_holds: assert property (@(posedge clk) disable iff (rst)
    (!empty && !pop) |=> !empty)
    else $error("waiting result dropped");
endmodule

bind transposition_table_engine tte_checker u_tte_checker (.*);

[tb/transposition_table_engine_tb.sv]
// Testbench for transposition_table_engine: random and directed probe, save
// and fill-query items checked against an in-bench table predictor.
// Depends on tte_pkg and the transposition_table_engine RTL.
`timescale 1ns / 100ps

module transposition_table_engine_tb;
  import tte_pkg::*;

  localparam int CLUSTERS = 1024;
  localparam int NWAYS    = 3;
  localparam int SAMPLES  = 1000;
  localparam int NENTRIES = CLUSTERS * NWAYS;
  localparam int CYCLE_LIMIT = 1500000;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic cfg_write = 1'b0;
  logic [4:0] cfg_data = '0;
  logic push = 1'b0;
  logic full, empty;
  logic pop = 1'b0;
  item_t drv = '0;
  res_t got;

  // predictor copy of the table
  logic [31:0] tbl_tag [NENTRIES];
  logic [15:0] tbl_da [NENTRIES];
  logic [47:0] tbl_pl [NENTRIES];
  logic [4:0] cur_gen;

  item_t pending_items[$];
  res_t expected_results[$];
  int errors = 0;
  int cycles = 0;
  bit in_idle_free = 0;
  int push_gap = 0;
  int pop_gap = 0;
  bit draining = 0;

  transposition_table_engine u_dut (
    .clk(clk), .rst(rst), .cfg_write(cfg_write), .cfg_data(cfg_data),
    .push(push), .full(full),
    .action(drv.action), .position_key(drv.position_key),
    .target_way(drv.target_way), .score_value(drv.score_value),
    .static_eval(drv.static_eval), .is_pv(drv.is_pv),
    .bound_kind(drv.bound_kind), .search_depth(drv.search_depth),
    .best_move(drv.best_move),
    .empty(empty), .pop(pop),
    .hit(got.hit), .chosen_way(got.chosen_way), .entry_depth(got.entry_depth),
    .entry_bound(got.entry_bound), .entry_pv(got.entry_pv),
    .entry_value(got.entry_value), .entry_eval(got.entry_eval),
    .entry_move(got.entry_move), .fill_permille(got.fill_permille)
  );

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  function automatic res_t entry_view(int idx, logic h, logic [1:0] w);
    res_t r;
    r = '0;
    r.hit = h;
    r.chosen_way = w;
    r.entry_depth = tbl_da[idx][15:8];
    r.entry_bound = tbl_da[idx][1:0];
    r.entry_pv = tbl_da[idx][2];
    r.entry_value = tbl_pl[idx][15:0];
    r.entry_eval = tbl_pl[idx][31:16];
    r.entry_move = tbl_pl[idx][47:32];
    return r;
  endfunction

  function automatic res_t table_predict(item_t it);
    res_t r;
    logic [7:0] gen8;
    logic [7:0] age;
    int base, idx, best, cnt;
    int score, best_score;
    logic differs;
    r = '0;
    gen8 = {cur_gen, 3'b000};
    base = (it.position_key % CLUSTERS) * NWAYS;
    case (it.action)
      ACT_PROBE: begin
        for (int i = 0; i < NWAYS; i++)
          if (tbl_tag[base + i] == it.position_key) begin
            tbl_da[base + i][7:3] = cur_gen;
            return entry_view(base + i, 1'b1, i[1:0]);
          end
        best = 0;
        best_score = 0;
        for (int i = 0; i < NWAYS; i++) begin
          age = (8'd7 + gen8 - tbl_da[base + i][7:0]) & 8'hF8;
          score = int'(tbl_da[base + i][15:8]) - int'(age);
          if (i == 0 || best_score > score) begin
            best_score = score;
            best = i;
          end
        end
        r = entry_view(base + best, 1'b0, best[1:0]);
      end
      ACT_SAVE: begin
        if (it.target_way < NWAYS) begin
          idx = base + it.target_way;
          differs = tbl_tag[idx] != it.position_key;
          if (it.best_move != 0 || differs) tbl_pl[idx][47:32] = it.best_move;
          if (differs || tbl_da[idx][15:8] < it.search_depth) begin
            tbl_tag[idx] = it.position_key;
            tbl_da[idx] = {it.search_depth, cur_gen, it.is_pv, it.bound_kind};
            tbl_pl[idx][31:0] = {it.static_eval, it.score_value};
          end
          r = entry_view(idx, 1'b0, it.target_way);
        end
      end
      ACT_FILL: begin
        cnt = 0;
        for (int i = 0; i < SAMPLES * NWAYS; i++)
          if (tbl_da[i][15:8] != 0 && tbl_da[i][7:3] == cur_gen) cnt++;
        r.fill_permille = 10'(cnt / NWAYS);
      end
      default: ;
    endcase
    return r;
  endfunction

  task automatic report_mismatch(string what, logic [31:0] g, logic [31:0] e);
    $display("mismatch %s: got %0h expected %0h", what, g, e);
    errors++;
  endtask

  // driver
  always @(posedge clk) begin
    if (!rst) begin
      if (push && !full) begin
        void'(pending_items.pop_front());
        expected_results.push_back(table_predict(drv));
      end
      if (push && full) begin
        // hold the current item
      end else if (pending_items.size() == 0 || draining) begin
        push <= 1'b0;
      end else if (push_gap > 0) begin
        push_gap <= push_gap - 1;
        push <= 1'b0;
      end else if (!in_idle_free && $urandom_range(0, 5) == 0) begin
        push_gap <= $urandom_range(0, 4);
        push <= 1'b0;
      end else begin
        // queue head after the accept above
        drv <= (push && !full) ? ((pending_items.size() > 0) ? pending_items[0] : drv)
                               : pending_items[0];
        push <= (push && !full) ? (pending_items.size() > 0) : 1'b1;
      end
    end
  end

  // monitor
  always @(posedge clk) begin
    res_t e;
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("timeout");
      $display("FAILED: results differ");
      $finish;
    end
    if (!rst) begin
      if (pop && !empty) begin
        if (expected_results.size() == 0) begin
          report_mismatch("unexpected result", 0, 0);
        end else begin
          e = expected_results.pop_front();
          if (got.hit !== e.hit) report_mismatch("hit", 32'(got.hit), 32'(e.hit));
          if (got.chosen_way !== e.chosen_way)
            report_mismatch("chosen_way", 32'(got.chosen_way), 32'(e.chosen_way));
          if (got.entry_depth !== e.entry_depth)
            report_mismatch("entry_depth", 32'(got.entry_depth), 32'(e.entry_depth));
          if (got.entry_bound !== e.entry_bound)
            report_mismatch("entry_bound", 32'(got.entry_bound), 32'(e.entry_bound));
          if (got.entry_pv !== e.entry_pv)
            report_mismatch("entry_pv", 32'(got.entry_pv), 32'(e.entry_pv));
          if (got.entry_value !== e.entry_value)
            report_mismatch("entry_value", 32'(got.entry_value), 32'(e.entry_value));
          if (got.entry_eval !== e.entry_eval)
            report_mismatch("entry_eval", 32'(got.entry_eval), 32'(e.entry_eval));
          if (got.entry_move !== e.entry_move)
            report_mismatch("entry_move", 32'(got.entry_move), 32'(e.entry_move));
          if (got.fill_permille !== e.fill_permille)
            report_mismatch("fill_permille", 32'(got.fill_permille),
                            32'(e.fill_permille));
        end
      end
      if (pop_gap > 0) begin
        pop_gap <= pop_gap - 1;
        pop <= 1'b0;
      end else if (!in_idle_free && $urandom_range(0, 5) == 0) begin
        pop_gap <= $urandom_range(0, 4);
        pop <= 1'b0;
      end else begin
        pop <= 1'b1;
      end
    end
  end

  // small key pool so probes and saves hit the same clusters
  logic [31:0] key_pool [16];

  function automatic item_t rand_item(int sz);
    item_t it;
    it.action = ($urandom_range(0, 199) == 0) ? ACT_FILL :
                ($urandom_range(0, 49) == 0) ? ACT_UNUSED :
                ($urandom_range(0, 1) ? ACT_SAVE : ACT_PROBE);
    it.position_key = ($urandom_range(0, 9) < 8) ? key_pool[$urandom_range(0, sz - 1)]
                                                 : $urandom;
    it.target_way = ($urandom_range(0, 19) == 0) ? 2'd3 : 2'($urandom_range(0, 2));
    it.score_value = 16'($urandom);
    it.static_eval = 16'($urandom);
    it.is_pv = 1'($urandom);
    it.bound_kind = 2'($urandom);
    it.search_depth = ($urandom_range(0, 9) == 0) ? 8'(0) : 8'($urandom);
    it.best_move = ($urandom_range(0, 3) == 0) ? 16'(0) : 16'($urandom);
    return it;
  endfunction

  task automatic wait_quiet();
    while (pending_items.size() > 0 || push)
      @(posedge clk);
    draining = 1;
    while (expected_results.size() > 0)
      @(posedge clk);
    repeat (1100) @(posedge clk);
    draining = 0;
  endtask

  task automatic set_generation(logic [4:0] g);
    @(posedge clk);
    cfg_write <= 1'b1;
    cfg_data <= g;
    cur_gen = g;
    @(posedge clk);
    cfg_write <= 1'b0;
  endtask

  initial begin
    item_t it;
    logic [4:0] gens [5] = '{5'd0, 5'd31, 5'd1, 5'd17, 5'd30};
    for (int i = 0; i < NENTRIES; i++) begin
      tbl_tag[i] = '0;
      tbl_da[i] = '0;
      tbl_pl[i] = '0;
    end
    cur_gen = '0;
    for (int i = 0; i < 16; i++) key_pool[i] = $urandom;
    key_pool[0] = 32'hFFFFFFFF;
    key_pool[1] = 32'h0000_0400; // cluster 0, the same cluster as key value 0
    repeat (5) @(posedge clk);
    rst <= 1'b0;
    set_generation(5'd31);

    // directed: empty-entry hit on key 0, extremes, every action
    it = '0;
    it.action = ACT_PROBE;  pending_items.push_back(it);
    it.action = ACT_FILL;   pending_items.push_back(it);
    it.action = ACT_UNUSED; pending_items.push_back(it);
    it = '1;
    it.action = ACT_SAVE; it.target_way = 2'd3; pending_items.push_back(it);
    for (int w = 0; w < 3; w++) begin
      it.target_way = 2'(w); it.position_key = 32'hFFFFFFFF - 32'(w * CLUSTERS);
      pending_items.push_back(it);
    end
    it.action = ACT_SAVE; it.target_way = 2'd0; it.position_key = 32'hFFFFFFFF;
    it.best_move = '0; it.search_depth = 8'd1; it.score_value = 16'sh8000;
    it.static_eval = 16'sh8000; pending_items.push_back(it);
    it.action = ACT_PROBE; pending_items.push_back(it);
    it.position_key = 32'h0000_03FF; pending_items.push_back(it);
    it.action = ACT_FILL; pending_items.push_back(it);
    wait_quiet();
    set_generation(5'd0);

    for (int ph = 0; ph < 5; ph++) begin
      for (int n = 0; n < 350; n++) pending_items.push_back(rand_item(ph == 0 ? 4 : 16));
      wait_quiet();
      set_generation(gens[ph]);
    end
    in_idle_free = 1;
    for (int n = 0; n < 200; n++) pending_items.push_back(rand_item(16));
    wait_quiet();
    if (errors == 0) begin
      $display("PASSED: all results match");
    end else begin
      $display("FAILED: results differ");
    end
    $finish;
  end

endmodule
